// ----- rtl/ttb_pkg.sv -----
// Shared constants and control types for the triangle tangent and bitangent block.
`default_nettype none
package ttb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int CNT_W       = $clog2(COORD_WIDTH);
  localparam int SEL_W       = 3;

  // Operand selection: six vector components and the UV determinant, which is computed first.
  localparam logic [SEL_W-1:0] SEL_FIRST = SEL_W'(0);
  localparam logic [SEL_W-1:0] SEL_LAST  = SEL_W'(5);
  localparam logic [SEL_W-1:0] SEL_DET   = SEL_W'(6);

  typedef struct packed {
    logic             store_vertex;
    logic             slot;
    logic             load_diffs;
    logic [SEL_W-1:0] sel;
    logic             mul;
    logic             second;
    logic             acc_load;
    logic             acc_sub;
    logic             det_store;
    logic             div_setup;
    logic             div_step;
    logic             div_finish;
    logic             out_load;
  } ttb_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic out_free;
  } ttb_status_t;

endpackage
`default_nettype wire

// ----- rtl/ttb_vertex_if.sv -----
// Vertex input channel: valid, ready and one vertex.
`default_nettype none
interface ttb_vertex_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_x;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_y;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_z;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] tex_u;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface
`default_nettype wire

// ----- rtl/ttb_result_if.sv -----
// Result channel: valid, ready and one tangent frame.
`default_nettype none
interface ttb_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] tangent_x;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] tangent_y;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] tangent_z;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] bitangent_x;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] bitangent_y;
  logic signed [ttb_pkg::COORD_WIDTH-1:0] bitangent_z;
  logic                                   degenerate;
  logic                                   clipped;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, clipped, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                bitangent_y, bitangent_z, degenerate, clipped, output ready);
endinterface
`default_nettype wire

// ----- rtl/ttb_ctrl.sv -----
// Sequencer that steps the shared multiplier and divider through one triangle.
`default_nettype none
module ttb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ttb_pkg::ttb_status_t status,
  output ttb_pkg::ttb_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_ACC, S_DET, S_DIVSET, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t                          state;
  logic [1:0]                      phase;
  logic [ttb_pkg::SEL_W-1:0]       sel;
  logic [ttb_pkg::CNT_W-1:0]       cnt;
  logic                            accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd              = '0;
    cmd.sel          = sel;
    cmd.slot         = phase[0];
    cmd.store_vertex = accept && (phase != 2'd2);
    cmd.load_diffs   = accept && (phase == 2'd2);
    case (state)
      S_MUL1: begin
        cmd.mul = 1'b1;
      end
      S_MUL2: begin
        cmd.mul      = 1'b1;
        cmd.second   = 1'b1;
        cmd.acc_load = 1'b1;
      end
      S_ACC:    cmd.acc_sub    = 1'b1;
      S_DET:    cmd.det_store  = 1'b1;
      S_DIVSET: cmd.div_setup  = 1'b1;
      S_DIV:    cmd.div_step   = 1'b1;
      S_FIN:    cmd.div_finish = 1'b1;
      S_OUT:    cmd.out_load   = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      sel   <= ttb_pkg::SEL_DET;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase == 2'd2) begin
              phase <= 2'd0;
              sel   <= ttb_pkg::SEL_DET;
              state <= S_MUL1;
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_ACC;
        S_ACC:  state <= (sel == ttb_pkg::SEL_DET) ? S_DET : S_DIVSET;
        S_DET: begin
          if (status.acc_zero) begin
            state <= S_OUT;
          end else begin
            sel   <= ttb_pkg::SEL_FIRST;
            state <= S_MUL1;
          end
        end
        S_DIVSET: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == ttb_pkg::CNT_W'(ttb_pkg::COORD_WIDTH - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sel == ttb_pkg::SEL_LAST) begin
            state <= S_OUT;
          end else begin
            sel   <= sel + 1'b1;
            state <= S_MUL1;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ttb_datapath.sv -----
// Vertex store, edge differences, shared multiplier, accumulator, divider and result register.
`default_nettype none
module ttb_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ttb_pkg::ttb_cmd_t                      cmd,
  output ttb_pkg::ttb_status_t                        status,
  input  wire logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [ttb_pkg::COORD_WIDTH-1:0] pos_z,
  input  wire logic signed [ttb_pkg::COORD_WIDTH-1:0] tex_u,
  input  wire logic signed [ttb_pkg::COORD_WIDTH-1:0] tex_v,
  ttb_result_if.source                                res
);

  localparam int CW = ttb_pkg::COORD_WIDTH;
  localparam int DW = ttb_pkg::DIFF_W;
  localparam int PW = ttb_pkg::PROD_W;
  localparam int AW = ttb_pkg::ACC_W;
  localparam int SW = AW + ttb_pkg::FRAC_BITS;

  logic signed [CW-1:0] hp [6];
  logic signed [CW-1:0] ht [4];
  logic signed [CW-1:0] pin [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic signed [DW-1:0] opa, opb, ta, tb, tc, td;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc, det;
  logic [AW-1:0]        amag, bmag_next, bmag, rem;
  logic [SW-1:0]        ash;
  logic [CW-1:0]        low, q, limit, mag, val;
  logic                 neg, ovf, sat, ge;
  logic [AW:0]          trial;
  logic signed [CW-1:0] comp [6];
  logic                 deg, clip;
  logic                 out_valid;

  assign pin[0] = pos_x;
  assign pin[1] = pos_y;
  assign pin[2] = pos_z;

  // Operands of the two products that make up each cross term.
  always_comb begin
    ta = du1;
    tb = dv2;
    tc = dv1;
    td = du2;
    case (cmd.sel)
      3'd0: begin ta = d1[0]; tb = dv2; tc = d2[0]; td = dv1; end
      3'd1: begin ta = d1[1]; tb = dv2; tc = d2[1]; td = dv1; end
      3'd2: begin ta = d1[2]; tb = dv2; tc = d2[2]; td = dv1; end
      3'd3: begin ta = d2[0]; tb = du1; tc = d1[0]; td = du2; end
      3'd4: begin ta = d2[1]; tb = du1; tc = d1[1]; td = du2; end
      3'd5: begin ta = d2[2]; tb = du1; tc = d1[2]; td = du2; end
      default: ;
    endcase
    opa = cmd.second ? tc : ta;
    opb = cmd.second ? td : tb;
  end

  // Divider set-up, one restoring step and the saturated signed result.
  always_comb begin
    amag      = acc[AW-1] ? AW'(-acc) : AW'(acc);
    bmag_next = det[AW-1] ? AW'(-det) : AW'(det);
    ash       = {amag, {ttb_pkg::FRAC_BITS{1'b0}}};
    trial     = {rem, low[CW-1]};
    ge        = (trial >= {1'b0, bmag});
    limit     = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    sat       = ovf || (q > limit);
    mag       = sat ? limit : q;
    val       = neg ? CW'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_vertex) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.slot) hp[3+i] <= pin[i];
        else hp[i] <= pin[i];
      end
      if (cmd.slot) begin
        ht[2] <= tex_u;
        ht[3] <= tex_v;
      end else begin
        ht[0] <= tex_u;
        ht[1] <= tex_v;
      end
    end
    if (cmd.load_diffs) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= DW'(hp[3+i]) - DW'(hp[i]);
        d2[i] <= DW'(pin[i]) - DW'(hp[i]);
      end
      du1 <= DW'(ht[2]) - DW'(ht[0]);
      dv1 <= DW'(ht[3]) - DW'(ht[1]);
      du2 <= DW'(tex_u) - DW'(ht[0]);
      dv2 <= DW'(tex_v) - DW'(ht[1]);
      for (int k = 0; k < 6; k++) comp[k] <= '0;
      deg  <= 1'b0;
      clip <= 1'b0;
    end
    if (cmd.mul) prod <= opa * opb;
    if (cmd.acc_load) acc <= AW'(prod);
    if (cmd.acc_sub) acc <= acc - AW'(prod);
    if (cmd.det_store) begin
      det <= acc;
      deg <= (acc == '0);
    end
    if (cmd.div_setup) begin
      neg  <= acc[AW-1] ^ det[AW-1];
      bmag <= bmag_next;
      // Quotient of 2^COORD_WIDTH or more shows when the high part already reaches the divisor.
      ovf  <= (AW'(ash[SW-1:CW]) >= bmag_next);
      rem  <= AW'(ash[SW-1:CW]);
      low  <= ash[CW-1:0];
      q    <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? AW'(trial - {1'b0, bmag}) : trial[AW-1:0];
      low <= {low[CW-2:0], 1'b0};
      q   <= {q[CW-2:0], ge};
    end
    if (cmd.div_finish) begin
      for (int k = 0; k < 6; k++) begin
        if (cmd.sel == ttb_pkg::SEL_W'(k)) comp[k] <= val;
      end
      clip <= clip | sat;
    end
    if (cmd.out_load) begin
      res.tangent_x   <= comp[0];
      res.tangent_y   <= comp[1];
      res.tangent_z   <= comp[2];
      res.bitangent_x <= comp[3];
      res.bitangent_y <= comp[4];
      res.bitangent_z <= comp[5];
      res.degenerate  <= deg;
      res.clipped     <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid       = out_valid;
  assign status.out_free = !out_valid || res.ready;
  assign status.acc_zero = (acc == '0);

endmodule
`default_nettype wire

// ----- rtl/triangle_tangent_bitangent.sv -----
// Top level of the triangle tangent and bitangent block.
//
//   Channel  Direction  Transaction
//   vertex   in         one vertex: pos_x, pos_y, pos_z, tex_u, tex_v (Q16.16)
//   frame    out        one triangle: tangent, bitangent, degenerate, clipped
//
// The first two vertices of a triangle are stored; the third starts the sequence:
// the determinant on the shared multiplier first, then for each of the six
// components two products on the shared multiplier and a restoring division.
// A degenerate triangle skips the six components and goes straight to the output.
// Reset clears the vertex count and the output valid; held vertices need no clearing.
// A result waiting on the frame channel does not stop the next vertices being taken.
`default_nettype none
module triangle_tangent_bitangent (
  input  wire logic    clk,
  input  wire logic    rst,
  ttb_vertex_if.sink   vertex,
  ttb_result_if.source frame
);

  ttb_pkg::ttb_cmd_t    cmd;
  ttb_pkg::ttb_status_t status;
  logic                 in_ready;

  assign vertex.ready = in_ready;

  ttb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertex.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .pos_x  (vertex.pos_x),
    .pos_y  (vertex.pos_y),
    .pos_z  (vertex.pos_z),
    .tex_u  (vertex.tex_u),
    .tex_v  (vertex.tex_v),
    .res    (frame)
  );

endmodule
`default_nettype wire

// ----- sim/triangle_tangent_bitangent_tb.sv -----
// Self-checking testbench for the triangle tangent and bitangent block.
`default_nettype none
module triangle_tangent_bitangent_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = ttb_pkg::COORD_WIDTH;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int RANDOM_VERTICES = 1250;
  localparam int DIRECTED_ROWS = 21;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t px, py, pz, tu, tv;
  } vertex_t;

  typedef struct packed {
    coord_t tx, ty, tz, bx, by, bz;
    logic   degenerate;
    logic   clipped;
  } frame_t;

  // One row of the directed table; has_fixed marks a typed-in frame.
  typedef struct packed {
    vertex_t vtx;
    logic    has_fixed;
    frame_t  fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttb_vertex_if vertex ();
  ttb_result_if frame ();

  triangle_tangent_bitangent u_dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex.sink),
    .frame  (frame.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the triangle assembly state.
  coord_t     held_pos [6];
  coord_t     held_tex [4];
  logic [1:0] corner_count;

  frame_t   expected_frames [$];
  int       mismatches;
  int       frames_seen;
  int       degenerate_seen;
  int       clipped_seen;
  int       idle_cycles;

  stim_row_t directed_rows [DIRECTED_ROWS];

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ONE  = coord_t'(1) <<< ttb_pkg::FRAC_BITS;

  // Truncating signed quotient scaled by 2^16, saturated to the field.
  function automatic coord_t scaled_quotient(input logic signed [130:0] num,
                                             input logic signed [130:0] den,
                                             inout logic clip);
    logic signed [130:0] q;
    logic signed [130:0] hi_lim;
    logic signed [130:0] lo_lim;
    begin
      hi_lim = 131'(CMAX);
      lo_lim = -(131'sd1 <<< (CW - 1));
      q = (num <<< ttb_pkg::FRAC_BITS) / den;
      if (q > hi_lim) begin
        clip = 1'b1;
        return CMAX;
      end
      if (q < lo_lim) begin
        clip = 1'b1;
        return CMIN;
      end
      return coord_t'(q);
    end
  endfunction

  // Advances the shadow state; returns 1 and the frame on a third corner.
  function automatic logic tangent_frame_of(input vertex_t v, output frame_t f);
    logic signed [130:0] d1 [3];
    logic signed [130:0] d2 [3];
    logic signed [130:0] du1, dv1, du2, dv2, det;
    coord_t cur [3];
    logic clip;
    begin
      f = '0;
      cur[0] = v.px;
      cur[1] = v.py;
      cur[2] = v.pz;
      if (corner_count < 2) begin
        for (int i = 0; i < 3; i++) held_pos[corner_count*3 + i] = cur[i];
        held_tex[corner_count*2]     = v.tu;
        held_tex[corner_count*2 + 1] = v.tv;
        corner_count = corner_count + 1;
        return 1'b0;
      end
      corner_count = 0;
      for (int i = 0; i < 3; i++) begin
        d1[i] = 131'(held_pos[3+i]) - 131'(held_pos[i]);
        d2[i] = 131'(cur[i]) - 131'(held_pos[i]);
      end
      du1 = 131'(held_tex[2]) - 131'(held_tex[0]);
      dv1 = 131'(held_tex[3]) - 131'(held_tex[1]);
      du2 = 131'(v.tu) - 131'(held_tex[0]);
      dv2 = 131'(v.tv) - 131'(held_tex[1]);
      det = du1 * dv2 - dv1 * du2;
      if (det == 0) begin
        f.degenerate = 1'b1;
        return 1'b1;
      end
      clip = 1'b0;
      f.tx = scaled_quotient(d1[0]*dv2 - d2[0]*dv1, det, clip);
      f.ty = scaled_quotient(d1[1]*dv2 - d2[1]*dv1, det, clip);
      f.tz = scaled_quotient(d1[2]*dv2 - d2[2]*dv1, det, clip);
      f.bx = scaled_quotient(d2[0]*du1 - d1[0]*du2, det, clip);
      f.by = scaled_quotient(d2[1]*du1 - d1[1]*du2, det, clip);
      f.bz = scaled_quotient(d2[2]*du1 - d1[2]*du2, det, clip);
      f.clipped = clip;
      return 1'b1;
    end
  endfunction

  function automatic vertex_t mk_vertex(input coord_t px, py, pz, tu, tv);
    vertex_t v;
    begin
      v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv;
      return v;
    end
  endfunction

  function automatic coord_t random_coord(input int mode);
    begin
      case (mode)
        0: return coord_t'($urandom);
        1: return coord_t'($urandom_range(0, 8)) <<< ttb_pkg::FRAC_BITS;
        2: return coord_t'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
        default: begin
          case ($urandom_range(0, 3))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            default: return -ONE;
          endcase
        end
      endcase
    end
  endfunction

  // Mostly small, sane coordinates; some full-range and extreme values.
  function automatic vertex_t random_vertex();
    int mode;
    begin
      mode = $urandom_range(0, 9);
      mode = (mode < 2) ? 0 : (mode < 4) ? 1 : (mode < 9) ? 2 : 3;
      return mk_vertex(random_coord(mode), random_coord(mode), random_coord(mode),
                       random_coord(mode), random_coord(mode));
    end
  endfunction

  initial begin
    frame_t z;
    frame_t deg;
    z = '0;
    deg = '0;
    deg.degenerate = 1'b1;
    // All-zero triangle straight after reset: degenerate.
    directed_rows[0] = '{mk_vertex(0, 0, 0, 0, 0), 1'b0, z};
    directed_rows[1] = '{mk_vertex(0, 0, 0, 0, 0), 1'b0, z};
    directed_rows[2] = '{mk_vertex(0, 0, 0, 0, 0), 1'b1, deg};
    // Unit triangle: tangent along x, bitangent along y.
    directed_rows[3] = '{mk_vertex(0, 0, 0, 0, 0), 1'b0, z};
    directed_rows[4] = '{mk_vertex(ONE, 0, 0, ONE, 0), 1'b0, z};
    directed_rows[5] = '{mk_vertex(0, ONE, 0, 0, ONE), 1'b1,
                         '{ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b0}};
    // Extreme positions with a tiny determinant: saturates.
    directed_rows[6] = '{mk_vertex(CMIN, CMIN, CMAX, 0, 0), 1'b0, z};
    directed_rows[7] = '{mk_vertex(CMAX, CMAX, CMIN, 1, 0), 1'b0, z};
    directed_rows[8] = '{mk_vertex(CMIN, CMAX, CMIN, 0, 1), 1'b0, z};
    // Extreme texture coordinates.
    directed_rows[9]  = '{mk_vertex(ONE, -ONE, 0, CMIN, CMAX), 1'b0, z};
    directed_rows[10] = '{mk_vertex(0, ONE, -ONE, CMAX, CMIN), 1'b0, z};
    directed_rows[11] = '{mk_vertex(-ONE, 0, ONE, CMIN, CMIN), 1'b0, z};
    // Collinear UVs: degenerate with non-zero positions.
    directed_rows[12] = '{mk_vertex(CMAX, 5, 7, ONE, ONE), 1'b0, z};
    directed_rows[13] = '{mk_vertex(3, CMIN, 9, 2*ONE, 2*ONE), 1'b0, z};
    directed_rows[14] = '{mk_vertex(1, 2, CMAX, 3*ONE, 3*ONE), 1'b1, deg};
    // All-ones bit patterns and mixed extremes.
    directed_rows[15] = '{mk_vertex(-1, -1, -1, -1, -1), 1'b0, z};
    directed_rows[16] = '{mk_vertex(CMAX, CMIN, CMAX, CMAX, -1), 1'b0, z};
    directed_rows[17] = '{mk_vertex(CMIN, CMAX, CMIN, -1, CMAX), 1'b0, z};
    // Last triangle in the table, complete within the table.
    directed_rows[18] = '{mk_vertex(ONE, ONE, ONE, ONE, 0), 1'b0, z};
    directed_rows[19] = '{mk_vertex(2*ONE, 0, ONE, 0, ONE), 1'b0, z};
    directed_rows[20] = '{mk_vertex(0, 3*ONE, -ONE, ONE, ONE), 1'b0, z};
  end

  task automatic send_vertex(input vertex_t v, input logic has_fixed, input frame_t fixed);
    frame_t f;
    int gap;
    begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        vertex.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vertex.valid <= 1'b1;
      vertex.pos_x <= v.px;
      vertex.pos_y <= v.py;
      vertex.pos_z <= v.pz;
      vertex.tex_u <= v.tu;
      vertex.tex_v <= v.tv;
      @(posedge clk);
      while (!vertex.ready) @(posedge clk);
      if (tangent_frame_of(v, f)) begin
        if (has_fixed && f != fixed)
          $display("Directed row prediction differs from the typed-in frame");
        expected_frames.push_back(has_fixed ? fixed : f);
      end
    end
  endtask

  // Result side: random stalls, whole-frame comparison, field-by-field report.
  initial begin
    int stall;
    frame_t got;
    frame_t exp_f;
    frame.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        frame.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame.ready <= 1'b1;
      @(posedge clk);
      while (!frame.valid) @(posedge clk);
      got = '{frame.tangent_x, frame.tangent_y, frame.tangent_z, frame.bitangent_x,
              frame.bitangent_y, frame.bitangent_z, frame.degenerate, frame.clipped};
      frames_seen++;
      if (got.degenerate) degenerate_seen++;
      if (got.clipped) clipped_seen++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected frame transaction: %p", got);
      end else begin
        exp_f = expected_frames.pop_front();
        if (got !== exp_f) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Frame mismatch %0d:", mismatches);
            $display("  tangent   exp %0d %0d %0d got %0d %0d %0d", exp_f.tx, exp_f.ty,
                     exp_f.tz, got.tx, got.ty, got.tz);
            $display("  bitangent exp %0d %0d %0d got %0d %0d %0d", exp_f.bx, exp_f.by,
                     exp_f.bz, got.bx, got.by, got.bz);
            $display("  degenerate exp %0b got %0b, clipped exp %0b got %0b",
                     exp_f.degenerate, got.degenerate, exp_f.clipped, got.clipped);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (rst || (vertex.valid && vertex.ready) || (frame.valid && frame.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_CYCLES);
    $display("Watchdog expired with %0d frames outstanding", expected_frames.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    int drain;
    mismatches = 0;
    frames_seen = 0;
    degenerate_seen = 0;
    clipped_seen = 0;
    corner_count = 0;
    foreach (held_pos[i]) held_pos[i] = '0;
    foreach (held_tex[i]) held_tex[i] = '0;
    vertex.valid = 1'b0;
    vertex.pos_x = '0;
    vertex.pos_y = '0;
    vertex.pos_z = '0;
    vertex.tex_u = '0;
    vertex.tex_v = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_vertex(directed_rows[i].vtx, directed_rows[i].has_fixed, directed_rows[i].fixed);
    for (int i = 0; i < RANDOM_VERTICES; i++)
      send_vertex(random_vertex(), 1'b0, '0);
    vertex.valid <= 1'b0;
    drain = 0;
    while (expected_frames.size() != 0 && drain < WATCHDOG_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d vertices; checked %0d frames (%0d degenerate, %0d saturated).",
             DIRECTED_ROWS + RANDOM_VERTICES, frames_seen, degenerate_seen, clipped_seen);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d frames missing", mismatches, expected_frames.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- triangle_tangent_bitangent.f -----
rtl/ttb_pkg.sv
rtl/ttb_vertex_if.sv
rtl/ttb_result_if.sv
rtl/ttb_ctrl.sv
rtl/ttb_datapath.sv
rtl/triangle_tangent_bitangent.sv
sim/triangle_tangent_bitangent_tb.sv
